@@ rtl/lfq_pkg.sv @@
// shared types and codes for the linked fifo with free list
`default_nettype none

package lfq_pkg;

  // request codes carried in req_type
  localparam logic REQ_PUSH = 1'b0;
  localparam logic REQ_POP  = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE   = 2'b01,
    ST_COMMIT = 2'b10
  } lfq_state_t;

  // controller to datapath
  typedef struct packed {
    logic start;   // word accepted, issue slot reads
    logic commit;  // update pointers, links and result register
  } lfq_cmd_t;

endpackage

`default_nettype wire

@@ rtl/lfq_req_if.sv @@
// request channel: push or pop word
`default_nettype none

interface lfq_req_if #(
  parameter int DATA_WIDTH = 32
);
  logic                  valid;
  logic                  ready;
  logic                  req_type;
  logic [DATA_WIDTH-1:0] data_in;

  modport source (output valid, output req_type, output data_in, input ready);
  modport sink   (input valid, input req_type, input data_in, output ready);
endinterface

`default_nettype wire

@@ rtl/lfq_rsp_if.sv @@
// response channel: status and popped word
`default_nettype none

interface lfq_rsp_if #(
  parameter int DATA_WIDTH = 32
);
  logic                  valid;
  logic                  ready;
  logic                  ok;
  logic [DATA_WIDTH-1:0] data_out;
  logic                  is_empty;
  logic                  is_full;

  modport source (output valid, output ok, output data_out, output is_empty,
                  output is_full, input ready);
  modport sink   (input valid, input ok, input data_out, input is_empty,
                  input is_full, output ready);
endinterface

`default_nettype wire

@@ rtl/lfq_ctrl.sv @@
// request sequencer: accept, then commit when the result register is free
`default_nettype none

module lfq_ctrl (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             req_valid,
  output logic                  req_ready,
  output logic                  rsp_valid,
  input  wire logic             rsp_ready,
  output lfq_pkg::lfq_cmd_t     cmd
);
  import lfq_pkg::*;

  lfq_state_t state;
  lfq_state_t state_next;

  assign req_ready  = (state == ST_IDLE);
  assign cmd.start  = req_valid && req_ready;
  assign cmd.commit = (state == ST_COMMIT) && (!rsp_valid || rsp_ready);

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (cmd.start) state_next = ST_COMMIT;
      end
      ST_COMMIT: begin
        if (cmd.commit) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.commit) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  a_commit_after_start: assert property (@(posedge clk) disable iff (rst)
    cmd.start |=> (state == ST_COMMIT))
    else $error("no commit phase after accepted word");

  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    (state == ST_COMMIT) && rsp_valid && !rsp_ready |=> (state == ST_COMMIT) && rsp_valid)
    else $error("pending result overwritten");

  a_no_accept_in_commit: assert property (@(posedge clk) disable iff (rst)
    cmd.commit |=> !rsp_valid || state == ST_IDLE)
    else $error("commit did not return to idle");

endmodule

`default_nettype wire

@@ rtl/lfq_dp.sv @@
// slot memories, list pointers and result register
`default_nettype none

module lfq_dp #(
  parameter int POOL_DEPTH = 16,
  parameter int DATA_WIDTH = 32
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire lfq_pkg::lfq_cmd_t     cmd,
  input  wire logic                  req_type,
  input  wire logic [DATA_WIDTH-1:0] data_in,
  output logic                       ok,
  output logic [DATA_WIDTH-1:0]      data_out,
  output logic                       is_empty,
  output logic                       is_full
);
  import lfq_pkg::*;

  localparam int IW = (POOL_DEPTH > 1) ? $clog2(POOL_DEPTH) : 1;
  localparam int LW = $clog2(POOL_DEPTH + 1);
  localparam logic [LW-1:0] NULL_LINK = LW'(POOL_DEPTH);

  logic [DATA_WIDTH-1:0] data_mem [POOL_DEPTH];
  logic [LW-1:0]         next_mem [POOL_DEPTH];

  logic [LW-1:0]         head;
  logic [LW-1:0]         tail;
  logic [LW-1:0]         free_head;
  logic [LW-1:0]         fresh;      // slots at and above this were never taken
  logic                  req_pop;
  logic [DATA_WIDTH-1:0] req_data;
  logic [DATA_WIDTH-1:0] rd_data;
  logic [LW-1:0]         rd_next;

  logic [LW-1:0]         head_next;
  logic [LW-1:0]         tail_next;
  logic [LW-1:0]         free_head_next;
  logic [LW-1:0]         fresh_next;
  logic                  ok_next;
  logic [DATA_WIDTH-1:0] data_out_next;
  logic                  head_ok;
  logic                  tail_ok;
  logic                  free_ok;
  logic                  data_we;
  logic [IW-1:0]         data_wa;
  logic                  next_we;
  logic [IW-1:0]         next_wa;
  logic [LW-1:0]         next_wd;
  logic [IW-1:0]         rd_addr;

  assign head_ok = (head != NULL_LINK);
  assign tail_ok = (tail != NULL_LINK);
  assign free_ok = (free_head != NULL_LINK);
  assign rd_addr = (req_type == REQ_POP) ? head[IW-1:0] : free_head[IW-1:0];

  always_comb begin
    head_next      = head;
    tail_next      = tail;
    free_head_next = free_head;
    fresh_next     = fresh;
    ok_next        = 1'b0;
    data_out_next  = '0;
    data_we        = 1'b0;
    data_wa        = free_head[IW-1:0];
    next_we        = 1'b0;
    next_wa        = tail[IW-1:0];
    next_wd        = free_head;
    if (req_pop == REQ_PUSH) begin
      if (free_ok) begin
        ok_next = 1'b1;
        data_we = 1'b1;
        // a never-used slot links to the next fresh one (null past the end)
        if (free_head == fresh) begin
          free_head_next = fresh + 1'b1;
          fresh_next     = fresh + 1'b1;
        end else begin
          free_head_next = rd_next;
        end
        if (tail_ok) begin
          next_we = 1'b1;
          next_wa = tail[IW-1:0];
          next_wd = free_head;
        end else begin
          head_next = free_head;
        end
        tail_next = free_head;
      end
    end else begin
      if (head_ok) begin
        ok_next       = 1'b1;
        data_out_next = rd_data;
        // tail link is never cleared, so last element is found by head == tail
        if (head == tail) begin
          head_next = NULL_LINK;
          tail_next = NULL_LINK;
        end else begin
          head_next = rd_next;
        end
        next_we        = 1'b1;
        next_wa        = head[IW-1:0];
        next_wd        = free_head;
        free_head_next = head;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      rd_data <= data_mem[rd_addr];
      rd_next <= next_mem[rd_addr];
    end
    if (cmd.commit && data_we) begin
      data_mem[data_wa] <= req_data;
    end
    if (cmd.commit && next_we) begin
      next_mem[next_wa] <= next_wd;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      req_pop  <= req_type;
      req_data <= data_in;
    end
    if (cmd.commit) begin
      ok       <= ok_next;
      data_out <= data_out_next;
      is_empty <= (head_next == NULL_LINK);
      is_full  <= (free_head_next == NULL_LINK);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head      <= NULL_LINK;
      tail      <= NULL_LINK;
      free_head <= '0;
      fresh     <= '0;
    end else if (cmd.commit) begin
      head      <= head_next;
      tail      <= tail_next;
      free_head <= free_head_next;
      fresh     <= fresh_next;
    end
  end

  a_head_tail_null: assert property (@(posedge clk) disable iff (rst)
    (head == NULL_LINK) == (tail == NULL_LINK))
    else $error("head and tail disagree on empty");

  a_free_below_fresh: assert property (@(posedge clk) disable iff (rst)
    free_head <= fresh && fresh <= NULL_LINK)
    else $error("free list head beyond fill count");

  a_push_fills: assert property (@(posedge clk) disable iff (rst)
    cmd.commit && req_pop == REQ_PUSH && free_ok |=> head != NULL_LINK && !is_empty)
    else $error("successful push left queue empty");

  a_pop_frees: assert property (@(posedge clk) disable iff (rst)
    cmd.commit && req_pop == REQ_POP && head_ok |=> free_head == $past(head) && !is_full)
    else $error("popped slot not returned to free list");

endmodule

`default_nettype wire

@@ rtl/linked_fifo_with_free_list_core.sv @@
// linked fifo in a slot pool with a lifo free list, top level
//
//   channel   dir  fields                              word
//   req_ch    in   req_type, data_in                   push (0) or pop (1)
//   rsp_ch    out  ok, data_out, is_empty, is_full     one per request
//
// each request has an accept step and a commit step: the accept edge reads the
// data and link of the head slot (pop) or free slot (push) from the synchronous
// slot memories, the commit edge writes back and updates the pointers.
// a new request is accepted in the cycle after commit while the previous
// result may still sit in the output register; a stalled output holds commit.
// rst is synchronous; no memory clearing pass, a fill count stands in for the
// initial free-list links.
`default_nettype none

module linked_fifo_with_free_list_core #(
  parameter int POOL_DEPTH = 16,
  parameter int DATA_WIDTH = 32
) (
  input  wire logic   clk,
  input  wire logic   rst,
  lfq_req_if.sink     req_ch,
  lfq_rsp_if.source   rsp_ch
);
  import lfq_pkg::*;

  lfq_cmd_t cmd;

  lfq_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_ch.valid),
    .req_ready (req_ch.ready),
    .rsp_valid (rsp_ch.valid),
    .rsp_ready (rsp_ch.ready),
    .cmd       (cmd)
  );

  lfq_dp #(
    .POOL_DEPTH (POOL_DEPTH),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_dp (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .req_type (req_ch.req_type),
    .data_in  (req_ch.data_in),
    .ok       (rsp_ch.ok),
    .data_out (rsp_ch.data_out),
    .is_empty (rsp_ch.is_empty),
    .is_full  (rsp_ch.is_full)
  );

endmodule

`default_nettype wire

@@ dv/lfq_checker.sv @@
// checker for the linked fifo: predicts each response and compares it with the block
module lfq_checker #(
  parameter int POOL_DEPTH = 16,
  parameter int DATA_WIDTH = 32
) (
  input  wire logic clk,
  input  wire logic rst,
  lfq_req_if        req_ch,
  lfq_rsp_if        rsp_ch,
  output int        errors,
  output int        pending
);
  import lfq_pkg::*;

  localparam int LINK_W = $clog2(POOL_DEPTH + 1);
  localparam logic [LINK_W-1:0] NO_LINK = LINK_W'(POOL_DEPTH);

  typedef struct packed {
    logic                  ok;
    logic [DATA_WIDTH-1:0] data;
    logic                  empty;
    logic                  full;
  } status_t;

  logic [DATA_WIDTH-1:0] slot_word [POOL_DEPTH];
  logic [LINK_W-1:0]     slot_link [POOL_DEPTH];
  logic [LINK_W-1:0]     head_ptr;
  logic [LINK_W-1:0]     tail_ptr;
  logic [LINK_W-1:0]     free_ptr;
  status_t               status_q[$];
  int                    mismatches = 0;
  int                    outstanding = 0;

  assign errors  = mismatches;
  assign pending = outstanding;

  function automatic logic in_pool(logic [LINK_W-1:0] link);
    return int'(link) < POOL_DEPTH;
  endfunction

  function automatic logic [LINK_W-1:0] clean(logic [LINK_W-1:0] link);
    return in_pool(link) ? link : NO_LINK;
  endfunction

  task automatic clear_pool();
    for (int i = 0; i < POOL_DEPTH; i++) begin
      slot_link[i] = (i + 1 < POOL_DEPTH) ? LINK_W'(i + 1) : NO_LINK;
    end
    head_ptr = NO_LINK;
    tail_ptr = NO_LINK;
    free_ptr = '0;
  endtask

  // applies one request to the predicted pool and returns the response it gives
  function automatic status_t serve(logic kind, logic [DATA_WIDTH-1:0] word);
    status_t           s;
    logic [LINK_W-1:0] slot;
    s = '0;
    if (kind == REQ_PUSH) begin
      slot = clean(free_ptr);
      if (in_pool(slot)) begin
        free_ptr = clean(slot_link[slot]);
        slot_link[slot] = NO_LINK;
        slot_word[slot] = word;
        if (in_pool(tail_ptr)) begin
          slot_link[tail_ptr] = slot;
        end else begin
          head_ptr = slot;
        end
        tail_ptr = slot;
        s.ok = 1'b1;
      end
    end else begin
      slot = clean(head_ptr);
      if (in_pool(slot)) begin
        s.data = slot_word[slot];
        head_ptr = clean(slot_link[slot]);
        // emptied queue drops the tail as well
        if (!in_pool(head_ptr)) begin
          tail_ptr = NO_LINK;
        end
        slot_link[slot] = clean(free_ptr);
        free_ptr = slot;
        s.ok = 1'b1;
      end
    end
    s.empty = !in_pool(head_ptr);
    s.full  = !in_pool(free_ptr);
    return s;
  endfunction

  task automatic check_field(string name, logic [DATA_WIDTH-1:0] want,
                             logic [DATA_WIDTH-1:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    status_t want;
    if (rst) begin
      clear_pool();
      status_q.delete();
    end else begin
      if (req_ch.valid && req_ch.ready) begin
        status_q.push_back(serve(req_ch.req_type, req_ch.data_in));
      end
      if (rsp_ch.valid && rsp_ch.ready) begin
        if (status_q.size() == 0) begin
          $display("%0t: response word mismatch, expected none, actual ok=%b data_out=%h",
                   $time, rsp_ch.ok, rsp_ch.data_out);
          mismatches++;
        end else begin
          want = status_q.pop_front();
          check_field("ok", DATA_WIDTH'(want.ok), DATA_WIDTH'(rsp_ch.ok));
          check_field("data_out", want.data, rsp_ch.data_out);
          check_field("is_empty", DATA_WIDTH'(want.empty), DATA_WIDTH'(rsp_ch.is_empty));
          check_field("is_full", DATA_WIDTH'(want.full), DATA_WIDTH'(rsp_ch.is_full));
        end
      end
    end
    outstanding <= status_q.size();
  end

endmodule

@@ dv/testbench.sv @@
// top of the linked fifo testbench: clock, reset, stimulus and verdict
module testbench;
  import lfq_pkg::*;

  localparam int POOL_DEPTH  = 16;
  localparam int DATA_WIDTH  = 32;
  localparam int CYCLE_LIMIT = 500000;

  logic clk;
  logic rst;
  int   snd_idle = 0;
  int   rcv_idle = 0;
  int   cycles = 0;
  int   errors;
  int   pending;

  lfq_req_if #(.DATA_WIDTH(DATA_WIDTH)) req_ch ();
  lfq_rsp_if #(.DATA_WIDTH(DATA_WIDTH)) rsp_ch ();

  linked_fifo_with_free_list_core #(
    .POOL_DEPTH(POOL_DEPTH),
    .DATA_WIDTH(DATA_WIDTH)
  ) dut (
    .clk    (clk),
    .rst    (rst),
    .req_ch (req_ch),
    .rsp_ch (rsp_ch)
  );

  lfq_checker #(
    .POOL_DEPTH(POOL_DEPTH),
    .DATA_WIDTH(DATA_WIDTH)
  ) checker_i (
    .clk     (clk),
    .rst     (rst),
    .req_ch  (req_ch),
    .rsp_ch  (rsp_ch),
    .errors  (errors),
    .pending (pending)
  );

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("** linked_fifo_with_free_list_core: FAILED **");
      $finish;
    end
  end

  // response side stalls at random
  initial begin
    rsp_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      rsp_ch.ready <= ($urandom_range(99) >= rcv_idle);
    end
  end

  // offers one request word and returns at the edge that accepts it
  task automatic put_word(input logic kind, input logic [DATA_WIDTH-1:0] word);
    while ($urandom_range(99) < snd_idle) begin
      req_ch.valid <= 1'b0;
      @(posedge clk);
    end
    req_ch.valid    <= 1'b1;
    req_ch.req_type <= kind;
    req_ch.data_in  <= word;
    do @(posedge clk); while (!req_ch.ready);
  endtask

  task automatic wait_drained();
    req_ch.valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  // bursts that lean toward filling, draining or churning the pool
  task automatic random_run(input int count);
    int                    seg_left;
    int                    push_pct;
    logic [DATA_WIDTH-1:0] word;
    seg_left = 0;
    push_pct = 50;
    for (int n = 0; n < count; n++) begin
      if (seg_left == 0) begin
        case ($urandom_range(2))
          0: push_pct = 85;
          1: push_pct = 15;
          default: push_pct = 50;
        endcase
        seg_left = $urandom_range(4, 40);
      end
      seg_left--;
      case ($urandom_range(15))
        0: word = '0;
        1: word = '1;
        default: word = $urandom;
      endcase
      put_word(($urandom_range(99) < push_pct) ? REQ_PUSH : REQ_POP, word);
    end
  endtask

  initial begin
    rst             <= 1'b1;
    req_ch.valid    <= 1'b0;
    req_ch.req_type <= REQ_PUSH;
    req_ch.data_in  <= '0;
    repeat (9) @(posedge clk);
    rst      <= 1'b0;
    snd_idle <= 11;
    rcv_idle <= 85;
    @(posedge clk);

    // empty pool, single element in and out, then empty again
    put_word(REQ_POP, 32'h1234_5678);
    put_word(REQ_PUSH, '1);
    put_word(REQ_POP, '0);
    put_word(REQ_POP, '1);
    // fill to full, refuse one, then reuse a freed slot
    for (int i = 0; i < POOL_DEPTH; i++) begin
      case (i)
        0: put_word(REQ_PUSH, '0);
        1: put_word(REQ_PUSH, '1);
        2: put_word(REQ_PUSH, 32'hAAAA_AAAA);
        3: put_word(REQ_PUSH, 32'h5555_5555);
        default: put_word(REQ_PUSH, (32'h1 << (2 * i)) | DATA_WIDTH'(i));
      endcase
    end
    put_word(REQ_PUSH, 32'hDEAD_BEEF);
    put_word(REQ_POP, '0);
    put_word(REQ_PUSH, 32'h8000_0001);
    put_word(REQ_POP, '0);

    random_run(470);
    wait_drained();
    snd_idle <= 85;
    rcv_idle <= 11;
    random_run(480);
    wait_drained();
    snd_idle <= 0;
    rcv_idle <= 0;
    random_run(500);
    wait_drained();
    repeat (20) @(posedge clk);

    if (errors == 0) begin
      $display("** linked_fifo_with_free_list_core: PASSED **");
    end else begin
      $display("** linked_fifo_with_free_list_core: FAILED **");
    end
    $finish;
  end

endmodule
